// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/bba_pkg.sv =====
`timescale 1ns / 1ps
package bba_pkg;

  // Default bitmap size and register reset
  localparam int NUM_BLOCKS_DEF = 64;
  localparam logic [6:0] TOTAL_RESET = 7'd50;

  // Field widths
  localparam int CNT_W    = 7;
  localparam int BLK_W    = 6;
  localparam int STAT_W   = 3;
  localparam int DATA_W   = 16;
  localparam int ADDR_W   = 3;
  localparam int APB_W    = 32;

  // Register map
  localparam logic [ADDR_W-1:0] ADDR_TOTAL = 3'd0;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_GRANT   = 3'd0,
    ST_REFUSE  = 3'd1,
    ST_FREED   = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_BADFREE = 3'd4
  } status_t;

  // Input op codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load_req;
    logic emit;
    logic rc_step;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cfg_wr;
    logic out_busy;
    logic finish;
    logic rc_last;
  } dp_stat_t;

endpackage

// ===== rtl/bitmap_block_allocator_unit.sv =====
`timescale 1ns / 1ps
// First-fit bitmap block allocator. One used/free bit per block; an allocate
// item for N blocks gives N grant items on the master side, lowest free blocks
// first, one per cycle while the master side does not stall, from a priority
// encoder over the bitmap. Free, empty and refused items give a single result.
// A result waits in an output register, and the next item is taken while it
// waits. Writing total_blocks starts a recount of the free blocks that sweeps
// the bitmap one bit a cycle; s_tready stays low until it ends.
module bitmap_block_allocator_unit #(
  parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // input items
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [bba_pkg::DATA_W-1:0]   s_tdata,   // count[6:0], target_block[12:7], zero
  input  logic                         s_tuser,   // op
  // result items
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [bba_pkg::DATA_W-1:0]   m_tdata,   // block_number[5:0], free_left[12:6], zero
  output logic [bba_pkg::STAT_W-1:0]   m_tuser,   // status
  output logic                         m_tlast,   // last
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bba_pkg::ADDR_W-1:0]   paddr,
  input  logic [bba_pkg::APB_W-1:0]    pwdata,
  output logic [bba_pkg::APB_W-1:0]    prdata,
  output logic                         pready
);
  import bba_pkg::*;

  ctrl_cmd_t          cmd;
  dp_stat_t           stat;
  logic               cfg_wr;
  logic [CNT_W-1:0]   total_blocks;
  logic [BLK_W-1:0]   block_number;
  status_t            status;
  logic [CNT_W-1:0]   free_left;

  // Register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_TOTAL);
  assign prdata = (paddr == ADDR_TOTAL) ? APB_W'(total_blocks) : '0;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bba_dp #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (s_tuser),
    .count        (s_tdata[CNT_W-1:0]),
    .target_block (s_tdata[CNT_W+BLK_W-1:CNT_W]),
    .ovalid       (m_tvalid),
    .oready       (m_tready),
    .block_number (block_number),
    .status       (status),
    .last         (m_tlast),
    .free_left    (free_left),
    .cfg_wr       (cfg_wr),
    .cfg_data     (pwdata[CNT_W-1:0]),
    .total_blocks (total_blocks),
    .cmd          (cmd),
    .stat         (stat)
  );

  // Pack result
  assign m_tdata = {{(DATA_W - BLK_W - CNT_W){1'b0}}, free_left, block_number};
  assign m_tuser = status;

endmodule

// ===== rtl/bba_ctrl.sv =====
`timescale 1ns / 1ps
module bba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  bba_pkg::dp_stat_t  stat,
  output bba_pkg::ctrl_cmd_t cmd
);
  import bba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RCNT = 3'b100
  } state_t;

  state_t state, state_next;

  // Handshake and commands
  always_comb begin
    s_tready     = (state == S_IDLE) && !stat.cfg_wr;
    cmd.load_req = s_tready && s_tvalid;
    cmd.emit     = (state == S_EXEC) && !stat.out_busy;
    cmd.rc_step  = (state == S_RCNT) && !stat.cfg_wr;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.load_req) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.emit && stat.finish) state_next = S_IDLE;
      end
      S_RCNT: begin
        if (cmd.rc_step && stat.rc_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    // a register write restarts the free recount
    if (stat.cfg_wr) state_next = S_RCNT;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

// ===== rtl/bba_dp.sv =====
`timescale 1ns / 1ps
module bba_dp #(
  parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // request in
  input  logic                          op,
  input  logic [bba_pkg::CNT_W-1:0]     count,
  input  logic [bba_pkg::BLK_W-1:0]     target_block,
  // result out
  output logic                          ovalid,
  input  logic                          oready,
  output logic [bba_pkg::BLK_W-1:0]     block_number,
  output bba_pkg::status_t              status,
  output logic                          last,
  output logic [bba_pkg::CNT_W-1:0]     free_left,
  // register port
  input  logic                          cfg_wr,
  input  logic [bba_pkg::CNT_W-1:0]     cfg_data,
  output logic [bba_pkg::CNT_W-1:0]     total_blocks,
  // control
  input  bba_pkg::ctrl_cmd_t            cmd,
  output bba_pkg::dp_stat_t             stat
);
  import bba_pkg::*;

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam logic [CNT_W-1:0] NB = CNT_W'(NUM_BLOCKS);
  localparam logic [CNT_W-1:0] FREE_RESET = (TOTAL_RESET > NB) ? NB : TOTAL_RESET;

  logic [NUM_BLOCKS-1:0] used_map;
  logic [CNT_W-1:0]      free_cnt;
  logic [IDX_W-1:0]      rc_idx;
  logic                  req_op;
  logic [CNT_W-1:0]      req_count;
  logic [BLK_W-1:0]      req_target;
  logic [CNT_W-1:0]      remain;
  logic                  granting;

  logic [CNT_W-1:0]      eff_total;
  logic [NUM_BLOCKS-1:0] in_range;
  logic [NUM_BLOCKS-1:0] avail;
  logic [NUM_BLOCKS-1:0] lowest;
  logic [IDX_W-1:0]      enc;
  logic [IDX_W-1:0]      tgt_idx;
  logic                  tgt_used;
  logic                  tgt_counted;
  logic                  is_grant;
  logic [BLK_W-1:0]      res_block;
  status_t               res_status;
  logic                  res_last;
  logic [CNT_W-1:0]      res_left;

  // Allocatable window and free bits
  always_comb begin
    eff_total = (total_blocks > NB) ? NB : total_blocks;
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      in_range[i] = CNT_W'(i) < eff_total;
    end
    avail = ~used_map & in_range;
  end

  // Lowest free block: isolate lowest set bit, then encode the one-hot word
  always_comb begin
    lowest = avail & (~avail + NUM_BLOCKS'(1));
    enc    = '0;
    for (int b = 0; b < IDX_W; b++) begin
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        if (((i >> b) & 1) == 1) enc[b] = enc[b] | lowest[i];
      end
    end
  end

  // Result of the current request step
  always_comb begin
    tgt_idx     = req_target[IDX_W-1:0];
    tgt_used    = ({1'b0, req_target} < NB) && used_map[tgt_idx];
    tgt_counted = {1'b0, req_target} < eff_total;
    is_grant    = 1'b0;
    res_block   = '0;
    res_last    = 1'b1;
    res_left    = free_cnt;
    res_status  = ST_GRANT;
    if (req_op == OP_FREE) begin
      if (tgt_used) begin
        res_block  = req_target;
        res_status = ST_FREED;
        res_left   = free_cnt + CNT_W'(tgt_counted);
      end else begin
        res_status = ST_BADFREE;
      end
    end else if (!granting && req_count == '0) begin
      res_status = ST_EMPTY;
    end else if (!granting && req_count > free_cnt) begin
      res_status = ST_REFUSE;
    end else begin
      is_grant   = 1'b1;
      res_block  = BLK_W'(enc);
      res_last   = (remain == CNT_W'(1));
      res_left   = free_cnt - CNT_W'(1);
    end
  end

  always_comb begin
    stat.cfg_wr   = cfg_wr;
    stat.out_busy = ovalid && !oready;
    stat.finish   = res_last;
    stat.rc_last  = (rc_idx == IDX_W'(NUM_BLOCKS - 1));
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op     <= op;
      req_count  <= count;
      req_target <= target_block;
    end
  end

  // Bitmap, free count, grant progress, recount sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      used_map     <= '0;
      free_cnt     <= FREE_RESET;
      total_blocks <= TOTAL_RESET;
      rc_idx       <= '0;
      remain       <= '0;
      granting     <= 1'b0;
    end else begin
      if (cmd.load_req) begin
        remain   <= count;
        granting <= 1'b0;
      end
      if (cfg_wr) begin
        total_blocks <= cfg_data;
        free_cnt     <= '0;
        rc_idx       <= '0;
      end else if (cmd.rc_step) begin
        free_cnt <= free_cnt + CNT_W'(avail[rc_idx]);
        rc_idx   <= rc_idx + IDX_W'(1);
      end else if (cmd.emit) begin
        free_cnt <= res_left;
        if (is_grant) begin
          used_map[enc] <= 1'b1;
          remain        <= remain - CNT_W'(1);
          granting      <= 1'b1;
        end else if (res_status == ST_FREED) begin
          used_map[tgt_idx] <= 1'b0;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst)             ovalid <= 1'b0;
    else if (cmd.emit)   ovalid <= 1'b1;
    else if (oready)     ovalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      block_number <= res_block;
      status       <= res_status;
      last         <= res_last;
      free_left    <= res_left;
    end
  end

endmodule

// ===== rtl/bba_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bba_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [bba_pkg::DATA_W-1:0]   m_tdata,
  input logic [bba_pkg::STAT_W-1:0]   m_tuser,
  input logic                         m_tlast
);
  import bba_pkg::*;

  logic noblk_kind;
  logic single_kind;

  // result kinds that name no block / that end their request at once
  assign noblk_kind  = (m_tuser == ST_REFUSE) || (m_tuser == ST_EMPTY) ||
                       (m_tuser == ST_BADFREE);
  assign single_kind = noblk_kind || (m_tuser == ST_FREED);

  // single-result kinds always close their request
  `ASSERT_IMPL(a_single_last, m_tvalid && single_kind, m_tlast)

  // results that name no block carry block zero
  `ASSERT_IMPL(a_noblk_zero, m_tvalid && noblk_kind, m_tdata[BLK_W-1:0] == '0)

  // one item at a time: an accepted item blocks the next cycle
  `ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)

  // stalled result stays offered
  `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (.*);
